// File: sv/floppy_sector_link_protocol_core_macros.svh
// assertion macros shared by the floppy sector link protocol core
// no dependencies; taken in by the modules that carry assertions
`ifndef FLOPPY_SECTOR_LINK_PROTOCOL_CORE_MACROS_SVH
`define FLOPPY_SECTOR_LINK_PROTOCOL_CORE_MACROS_SVH

// same-cycle implication
`define FSLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fslp same-cycle check failed");

// next-cycle implication
`define FSLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fslp next-cycle check failed");

`endif

// File: sv/fslp_pkg.sv
// types, codes and constants of the floppy sector link protocol core
// no dependencies; used by all modules of the block
package fslp_pkg;

   localparam int SECS_PER_TRACK = 26;
   localparam int HALF_TRACK     = 13;
   localparam int TRACK_SKEW     = 6;
   localparam int RETRY_RESET    = 8;

   localparam int BUF_DEPTH   = 128;
   localparam int BUF_ADDR_W  = $clog2(BUF_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // block / 26 as (block * 2521) >> 16, exact for 11-bit blocks
   localparam int TRK_RECIP  = 2521;
   localparam int TRK_SHIFT  = 16;
   localparam int TRK_PROD_W = 23;

   localparam logic REG_RETRY_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_RX    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      RX_DATA     = 2'd0,
      RX_COMPLETE = 2'd1,
      RX_ERROR    = 2'd2,
      RX_CONSOLE  = 2'd3
   } rx_kind_type;

   typedef enum logic [1:0] {
      SEND_READ_CMD  = 2'd0,
      SEND_WRITE_CMD = 2'd1,
      SEND_DATA      = 2'd2,
      SEND_CANCEL    = 2'd3
   } send_kind_type;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_CMD    = 8'b0000_0010,
      PH_SEC    = 8'b0000_0100,
      PH_TRK    = 8'b0000_1000,
      PH_XDATA  = 8'b0001_0000,
      PH_WAIT   = 8'b0010_0000,
      PH_RDATA  = 8'b0100_0000,
      PH_CANCEL = 8'b1000_0000
   } phase_type;

   localparam logic [2:0] PC_IDLE   = 3'd0;
   localparam logic [2:0] PC_CMD    = 3'd1;
   localparam logic [2:0] PC_SEC    = 3'd2;
   localparam logic [2:0] PC_TRK    = 3'd3;
   localparam logic [2:0] PC_XDATA  = 3'd4;
   localparam logic [2:0] PC_WAIT   = 3'd5;
   localparam logic [2:0] PC_RDATA  = 3'd6;
   localparam logic [2:0] PC_CANCEL = 3'd7;

   // one queued request, already decoded by the front end
   typedef struct packed {
      action_type             action;
      logic [BUF_ADDR_W-1:0]  index;
      logic [7:0]             byte_value;
      logic [6:0]             track;
      logic [4:0]             sector;
      logic                   out_of_range;
      logic                   is_read;
      rx_kind_type            rx_kind;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic logic [2:0] phase_code(phase_type ph);
      logic [2:0] c;
      unique case (ph)
         PH_IDLE:   c = PC_IDLE;
         PH_CMD:    c = PC_CMD;
         PH_SEC:    c = PC_SEC;
         PH_TRK:    c = PC_TRK;
         PH_XDATA:  c = PC_XDATA;
         PH_WAIT:   c = PC_WAIT;
         PH_RDATA:  c = PC_RDATA;
         PH_CANCEL: c = PC_CANCEL;
         default:   c = PC_IDLE;
      endcase
      return c;
   endfunction

   // (track * 6) mod 26 for every 7-bit track
   function automatic logic [127:0][4:0] build_skew_table();
      logic [127:0][4:0] t;
      logic [5:0]        acc;
      acc = '0;
      for (int i = 0; i < 128; i++) begin
         t[i] = acc[4:0];
         acc  = acc + 6'(TRACK_SKEW);
         if (acc >= 6'(SECS_PER_TRACK)) begin
            acc = acc - 6'(SECS_PER_TRACK);
         end
      end
      return t;
   endfunction

   localparam logic [127:0][4:0] SKEW_TABLE = build_skew_table();

endpackage

// File: sv/fslp_front.sv
// front end: accepts requests, splits the block number into track and sector
// depends on fslp_pkg; feeds fslp_queue
module fslp_front #(
   parameter int TRACK_COUNT = 77
) (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [6:0]               req_index,
   input  logic [7:0]               req_byte_value,
   input  logic [10:0]              req_block_number,
   input  logic                     req_is_read,
   input  logic [1:0]               req_rx_kind,
   input  fslp_pkg::q_status_type   q_status,
   output logic                     push,
   output fslp_pkg::item_type       push_item
);

   localparam logic [10:0] BLOCK_LIMIT = 11'((TRACK_COUNT - 1) * fslp_pkg::SECS_PER_TRACK);

   logic [fslp_pkg::TRK_PROD_W-1:0] prod;
   logic [6:0]                      trk;
   logic [10:0]                     trk_x26;
   logic [10:0]                     sec_full;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // quotient by reciprocal, remainder by back-multiply
   assign prod     = fslp_pkg::TRK_PROD_W'(req_block_number)
                   * fslp_pkg::TRK_PROD_W'(fslp_pkg::TRK_RECIP);
   assign trk      = prod[fslp_pkg::TRK_SHIFT +: 7];
   assign trk_x26  = 11'(trk) * 11'(fslp_pkg::SECS_PER_TRACK);
   assign sec_full = req_block_number - trk_x26;

   always_comb begin
      push_item.action       = fslp_pkg::action_type'(req_action);
      push_item.index        = req_index;
      push_item.byte_value   = req_byte_value;
      push_item.track        = trk;
      push_item.sector       = sec_full[4:0];
      push_item.out_of_range = (req_block_number >= BLOCK_LIMIT);
      push_item.is_read      = req_is_read;
      push_item.rx_kind      = fslp_pkg::rx_kind_type'(req_rx_kind);
   end

endmodule

// File: sv/fslp_queue.sv
// two-entry request queue between front end and back end
// depends on fslp_pkg and the shared assertion macros
`include "floppy_sector_link_protocol_core_macros.svh"
module fslp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fslp_pkg::item_type       push_item,
   input  logic                     pop,
   output fslp_pkg::q_status_type   q_status,
   output fslp_pkg::item_type       head_item
);

   fslp_pkg::item_type                entry_ff [fslp_pkg::QUEUE_DEPTH];
   logic [fslp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fslp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fslp_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? fslp_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? fslp_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = fslp_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = fslp_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == fslp_pkg::QCNT_W'(fslp_pkg::QUEUE_DEPTH));
   assign head_item          = entry_ff[rd_ptr_ff];

   `FSLP_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !q_status.full)
   `FSLP_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop, q_status.not_empty)

endmodule

// File: sv/fslp_back.sv
// back end: protocol sequencer, sector buffer and result register
// depends on fslp_pkg and the shared assertion macros
`include "floppy_sector_link_protocol_core_macros.svh"
module fslp_back #(
   parameter int SECTOR_BYTES = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               retry_limit,
   input  fslp_pkg::q_status_type   q_status,
   input  fslp_pkg::item_type       head_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_send_valid,
   output logic [1:0]               rsp_send_kind,
   output logic [7:0]               rsp_send_byte,
   output logic                     rsp_read_valid,
   output logic [6:0]               rsp_read_index,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_done_res,
   output logic                     rsp_failed,
   output logic                     rsp_bad_block,
   output logic [2:0]               rsp_phase_now
);

   localparam int AW = fslp_pkg::BUF_ADDR_W;

   // protocol state
   fslp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]          sector_ff, sector_in;
   logic [6:0]          track_ff, track_in;
   logic                read_mode_ff, read_mode_in;
   logic [7:0]          remaining_ff, remaining_in;
   logic [AW-1:0]       position_ff, position_in;
   logic [3:0]          retries_ff, retries_in;

   // sector buffer
   logic [7:0]          buffer_ff [fslp_pkg::BUF_DEPTH];
   logic [7:0]          buf_q_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr;
   logic [7:0]          mem_wdata;

   // result register
   logic                    o_valid_ff;
   logic                    o_send_valid_ff, o_send_valid_in;
   fslp_pkg::send_kind_type o_send_kind_ff, o_send_kind_in;
   logic [7:0]              o_send_byte_ff, o_send_byte_in;
   logic                    o_from_buf_ff, o_from_buf_in;
   logic                    o_read_valid_ff, o_read_valid_in;
   logic [AW-1:0]           o_read_index_ff, o_read_index_in;
   logic [7:0]              o_read_byte_ff, o_read_byte_in;
   logic                    o_done_ff, o_done_in;
   logic                    o_failed_ff, o_failed_in;
   logic                    o_bad_ff, o_bad_in;
   logic [2:0]              o_phase_ff, o_phase_in;

   logic       fire;
   logic [4:0] next_retry;
   logic [7:0] rem_dec;
   logic [5:0] sec_twice;
   logic [5:0] sec_inter;
   logic [5:0] sec_sum;
   logic [5:0] sec_mod;

   assign fire = q_status.not_empty && (!o_valid_ff || !rsp_stall);
   assign pop  = fire;

   // 2:1 interleave plus track skew, all values below 52
   always_comb begin
      sec_twice = {head_item.sector, 1'b0};
      sec_inter = (head_item.sector < 5'(fslp_pkg::HALF_TRACK))
                ? sec_twice
                : 6'(sec_twice - 6'(2 * fslp_pkg::HALF_TRACK - 1));
      sec_sum   = sec_inter + {1'b0, fslp_pkg::SKEW_TABLE[head_item.track]};
      sec_mod   = (sec_sum >= 6'(fslp_pkg::SECS_PER_TRACK))
                ? 6'(sec_sum - 6'(fslp_pkg::SECS_PER_TRACK))
                : sec_sum;
   end

   assign next_retry = {1'b0, retries_ff} + 5'd1;
   assign rem_dec    = remaining_ff - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      sector_in    = sector_ff;
      track_in     = track_ff;
      read_mode_in = read_mode_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      retries_in   = retries_ff;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = head_item.index;
      mem_wdata = head_item.byte_value;

      o_send_valid_in = 1'b0;
      o_send_kind_in  = fslp_pkg::SEND_READ_CMD;
      o_send_byte_in  = 8'd0;
      o_from_buf_in   = 1'b0;
      o_read_valid_in = 1'b0;
      o_read_index_in = '0;
      o_read_byte_in  = 8'd0;
      o_done_in       = 1'b0;
      o_failed_in     = 1'b0;
      o_bad_in        = 1'b0;

      if (fire) begin
         unique case (head_item.action)
            fslp_pkg::ACT_LOAD: begin
               mem_we = (phase_ff == fslp_pkg::PH_IDLE);
            end
            fslp_pkg::ACT_START: begin
               if (phase_ff != fslp_pkg::PH_IDLE || head_item.out_of_range) begin
                  o_bad_in = 1'b1;
               end else begin
                  track_in     = 7'(head_item.track + 7'd1);
                  sector_in    = 5'(sec_mod + 6'd1);
                  read_mode_in = head_item.is_read;
                  retries_in   = 4'd0;
                  phase_in     = fslp_pkg::PH_CMD;
               end
            end
            fslp_pkg::ACT_TICK: begin
               unique case (phase_ff)
                  fslp_pkg::PH_CMD: begin
                     remaining_in    = 8'(SECTOR_BYTES);
                     position_in     = '0;
                     o_send_valid_in = 1'b1;
                     o_send_kind_in  = read_mode_ff ? fslp_pkg::SEND_READ_CMD
                                                    : fslp_pkg::SEND_WRITE_CMD;
                     phase_in        = fslp_pkg::PH_SEC;
                  end
                  fslp_pkg::PH_SEC: begin
                     o_send_valid_in = 1'b1;
                     o_send_kind_in  = fslp_pkg::SEND_DATA;
                     o_send_byte_in  = {3'b000, sector_ff};
                     phase_in        = fslp_pkg::PH_TRK;
                  end
                  fslp_pkg::PH_TRK: begin
                     o_send_valid_in = 1'b1;
                     o_send_kind_in  = fslp_pkg::SEND_DATA;
                     o_send_byte_in  = {1'b0, track_ff};
                     phase_in        = read_mode_ff ? fslp_pkg::PH_WAIT
                                                    : fslp_pkg::PH_XDATA;
                  end
                  fslp_pkg::PH_XDATA: begin
                     // byte comes out of the buffer read register
                     mem_re          = 1'b1;
                     o_send_valid_in = 1'b1;
                     o_send_kind_in  = fslp_pkg::SEND_DATA;
                     o_from_buf_in   = 1'b1;
                     position_in     = AW'(position_ff + 1'b1);
                     remaining_in    = rem_dec;
                     if (rem_dec == 8'd0) begin
                        phase_in = fslp_pkg::PH_WAIT;
                     end
                  end
                  fslp_pkg::PH_CANCEL: begin
                     o_send_valid_in = 1'b1;
                     o_send_kind_in  = fslp_pkg::SEND_CANCEL;
                     if (next_retry <= {1'b0, retry_limit}) begin
                        retries_in = next_retry[3:0];
                        phase_in   = fslp_pkg::PH_CMD;
                     end else begin
                        o_done_in   = 1'b1;
                        o_failed_in = 1'b1;
                        phase_in    = fslp_pkg::PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            fslp_pkg::ACT_RX: begin
               if (phase_ff != fslp_pkg::PH_IDLE) begin
                  case (head_item.rx_kind)
                     fslp_pkg::RX_DATA: begin
                        if (phase_ff != fslp_pkg::PH_RDATA) begin
                           phase_in = fslp_pkg::PH_CANCEL;
                        end else begin
                           mem_we          = 1'b1;
                           mem_waddr       = position_ff;
                           o_read_valid_in = 1'b1;
                           o_read_index_in = position_ff;
                           o_read_byte_in  = head_item.byte_value;
                           position_in     = AW'(position_ff + 1'b1);
                           remaining_in    = rem_dec;
                           if (rem_dec == 8'd0) begin
                              phase_in  = fslp_pkg::PH_IDLE;
                              o_done_in = 1'b1;
                           end
                        end
                     end
                     fslp_pkg::RX_COMPLETE: begin
                        if (phase_ff != fslp_pkg::PH_WAIT || head_item.byte_value != 8'd0) begin
                           phase_in = fslp_pkg::PH_CANCEL;
                        end else if (read_mode_ff) begin
                           phase_in = fslp_pkg::PH_RDATA;
                        end else begin
                           phase_in  = fslp_pkg::PH_IDLE;
                           o_done_in = 1'b1;
                        end
                     end
                     fslp_pkg::RX_ERROR: begin
                        phase_in = fslp_pkg::PH_CANCEL;
                     end
                     default: begin
                        // console traffic passes by
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      o_phase_in = fslp_pkg::phase_code(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fslp_pkg::PH_IDLE;
         sector_ff    <= '0;
         track_ff     <= '0;
         read_mode_ff <= 1'b0;
         remaining_ff <= '0;
         position_ff  <= '0;
         retries_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         sector_ff    <= sector_in;
         track_ff     <= track_in;
         read_mode_ff <= read_mode_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         retries_ff   <= retries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         buffer_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         buf_q_ff <= buffer_ff[position_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (fire) begin
         o_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         o_send_valid_ff <= o_send_valid_in;
         o_send_kind_ff  <= o_send_kind_in;
         o_send_byte_ff  <= o_send_byte_in;
         o_from_buf_ff   <= o_from_buf_in;
         o_read_valid_ff <= o_read_valid_in;
         o_read_index_ff <= o_read_index_in;
         o_read_byte_ff  <= o_read_byte_in;
         o_done_ff       <= o_done_in;
         o_failed_ff     <= o_failed_in;
         o_bad_ff        <= o_bad_in;
         o_phase_ff      <= o_phase_in;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_send_valid = o_send_valid_ff;
   assign rsp_send_kind  = o_send_kind_ff;
   assign rsp_send_byte  = o_from_buf_ff ? buf_q_ff : o_send_byte_ff;
   assign rsp_read_valid = o_read_valid_ff;
   assign rsp_read_index = o_read_index_ff;
   assign rsp_read_byte  = o_read_byte_ff;
   assign rsp_done_res   = o_done_ff;
   assign rsp_failed     = o_failed_ff;
   assign rsp_bad_block  = o_bad_ff;
   assign rsp_phase_now  = o_phase_ff;

   `FSLP_ASSERT_NOW(a_phase_onehot, clock, reset, 1'b1, $onehot(phase_ff))
   `FSLP_ASSERT_NOW(a_data_count_consistent, clock, reset,
                    phase_ff == fslp_pkg::PH_XDATA || phase_ff == fslp_pkg::PH_RDATA,
                    remaining_ff != 8'd0 && (8'(position_ff) + remaining_ff) == 8'(SECTOR_BYTES))
   `FSLP_ASSERT_NEXT(a_done_goes_idle, clock, reset,
                     fire && o_done_in, phase_ff == fslp_pkg::PH_IDLE && rsp_done_res)

endmodule

// File: sv/floppy_sector_link_protocol_core.sv
// top level of the floppy sector link protocol core: csr block and wiring
// depends on fslp_pkg, fslp_front, fslp_queue and fslp_back
//
//  port group | direction | handshake           | payload
//  req_*      | in        | req_valid/req_stall | action, index, byte, block, dir, rx kind
//  rsp_*      | out       | rsp_valid/rsp_stall | send, read data, done, failed, bad, phase
//  csr_*      | in/out    | psel/penable/pready | retry_limit at byte address 0
//
// one request per cycle sustained while rsp_stall is low; a taken request is first
// queued (the front end is combinational) and registered when the sequencer pops it
// the sequencer and its result register set the rate: each request's phase update
// is registered as the request is popped, so the next request follows right behind it
// reset is synchronous and active high; it clears the protocol state, queue and
// retry_limit (to 8) but leaves the sector buffer contents as they were
// a stalled result holds the sequencer; the two-entry queue then fills and
// req_stall rises, so each side stalls without blocking the other immediately
module floppy_sector_link_protocol_core #(
   parameter int SECTOR_BYTES = 128,
   parameter int TRACK_COUNT  = 77
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_index,
   input  logic [7:0]  req_byte_value,
   input  logic [10:0] req_block_number,
   input  logic        req_is_read,
   input  logic [1:0]  req_rx_kind,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_valid,
   output logic [1:0]  rsp_send_kind,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_read_valid,
   output logic [6:0]  rsp_read_index,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_done_res,
   output logic        rsp_failed,
   output logic        rsp_bad_block,
   output logic [2:0]  rsp_phase_now,

   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // retry_limit register
   logic [3:0] retry_limit_ff, retry_limit_in;
   logic       csr_write;
   logic       csr_hit;

   // links between front end, queue and sequencer
   fslp_pkg::q_status_type q_status;
   fslp_pkg::item_type     push_item;
   fslp_pkg::item_type     head_item;
   logic                   push;
   logic                   pop;

   // csr access: register index sits above the two byte-offset bits
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == fslp_pkg::REG_RETRY_LIMIT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      retry_limit_in = retry_limit_ff;
      if (csr_write && csr_hit) begin
         retry_limit_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 4'(fslp_pkg::RETRY_RESET);
      end else begin
         retry_limit_ff <= retry_limit_in;
      end
   end

   assign csr_prdata = csr_hit ? {28'd0, retry_limit_ff} : 32'd0;

   // front end: take requests, map block number to track and raw sector
   fslp_front #(
      .TRACK_COUNT (TRACK_COUNT)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_byte_value   (req_byte_value),
      .req_block_number (req_block_number),
      .req_is_read      (req_is_read),
      .req_rx_kind      (req_rx_kind),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   // decoupling queue
   fslp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_status  (q_status),
      .head_item (head_item)
   );

   // back end: protocol sequencer, sector buffer and result register
   fslp_back #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .retry_limit    (retry_limit_ff),
      .q_status       (q_status),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_send_valid (rsp_send_valid),
      .rsp_send_kind  (rsp_send_kind),
      .rsp_send_byte  (rsp_send_byte),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_index (rsp_read_index),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_failed     (rsp_failed),
      .rsp_bad_block  (rsp_bad_block),
      .rsp_phase_now  (rsp_phase_now)
   );

endmodule
